@@ src/costh_pkg.sv @@
// ----------------------------------------------------------------------------
// Circle / oriented strip hit test: shared definitions
// Widths, constants, codes and the stage payload types used by every stage.
// ----------------------------------------------------------------------------
package costh_pkg;

  localparam int COORD_W     = 24;
  localparam int OFS_W       = COORD_W + 1;
  localparam int DSQ_W       = 2 * COORD_W - 1;
  localparam int L2_W        = 2 * COORD_W;
  localparam int M_W         = 62;
  localparam int ROOT_W      = 31;
  localparam int SQRT_W      = 63;
  localparam int SQRT_STAGES = 31;
  localparam int DIV_STAGES  = 31;
  localparam int REM_W       = ROOT_W + 1;
  localparam int UNIT_W      = 32;
  localparam int UNIT_BITS   = 30;
  localparam int GUARD_BITS  = 6;
  localparam int PROJ_SHIFT  = UNIT_BITS - GUARD_BITS;
  localparam int PROD_W      = OFS_W + UNIT_W;
  localparam int LOC_W       = 34;
  localparam int ROT_W       = 36;
  localparam int WIDE_W      = 64;
  localparam int GAP_W       = 32;
  localparam int DIST_W      = 64;
  localparam int INC_W       = 31;
  localparam int TOL_W       = 12;
  localparam int GEOM_STAGES = 9;

  localparam logic [30:0]      SIN60_Q30 = 31'd929887697;
  localparam int               COS60_SHIFT = 29;
  localparam logic [TOL_W-1:0] TOL_RESET = 12'd3;
  localparam logic             REG_TOL   = 1'b0;

  typedef enum logic [1:0] {
    KIND_BOX    = 2'd0,
    KIND_CROSS  = 2'd1,
    KIND_STAR   = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REASON_NONE   = 2'd0,
    REASON_RADIUS = 2'd1,
    REASON_EXTENT = 2'd2,
    REASON_DIR    = 2'd3
  } reason_t;

  // Per-query data that rides along the whole pipe
  typedef struct packed {
    kind_t              kind;
    reason_t            reason;
    logic [OFS_W-1:0]   ox;
    logic [OFS_W-1:0]   oz;
    logic [COORD_W-1:0] len;
    logic [COORD_W-1:0] wid;
    logic [COORD_W-1:0] rad;
  } meta_t;

  // Sideband through the root and divide stages
  typedef struct packed {
    meta_t             meta;
    logic              neg_x;
    logic              neg_z;
    logic [ROOT_W-1:0] ax;
    logic [ROOT_W-1:0] az;
  } side_t;

  // Distance from p to [lo, hi] along one axis, capped at 2^31
  function automatic logic [GAP_W-1:0] axis_gap(input logic signed [ROT_W-1:0] p,
                                                input logic signed [ROT_W-1:0] lo,
                                                input logic signed [ROT_W-1:0] hi);
    logic signed [ROT_W:0] d;
    d = '0;
    if (p < lo) begin
      d = (ROT_W+1)'(lo) - (ROT_W+1)'(p);
    end else if (p > hi) begin
      d = (ROT_W+1)'(p) - (ROT_W+1)'(hi);
    end
    if (d > $signed((ROT_W+1)'(33'h0_8000_0000))) begin
      return GAP_W'(33'h0_8000_0000);
    end
    return d[GAP_W-1:0];
  endfunction

endpackage

@@ src/costh_front.sv @@
// ----------------------------------------------------------------------------
// Front end
// Checks the query, forms offsets and squared direction length, then
// normalizes the squared length into [2^60, 2^62) for the root stages.
// ----------------------------------------------------------------------------
module costh_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [1:0]                          kind,
  input  logic signed [costh_pkg::COORD_W-1:0] target_x,
  input  logic signed [costh_pkg::COORD_W-1:0] target_z,
  input  logic signed [costh_pkg::COORD_W-1:0] target_radius,
  input  logic signed [costh_pkg::COORD_W-1:0] shape_x,
  input  logic signed [costh_pkg::COORD_W-1:0] shape_z,
  input  logic signed [costh_pkg::COORD_W-1:0] dir_x,
  input  logic signed [costh_pkg::COORD_W-1:0] dir_z,
  input  logic signed [costh_pkg::COORD_W-1:0] extent_length,
  input  logic signed [costh_pkg::COORD_W-1:0] extent_width,
  output logic                                out_valid,
  output costh_pkg::side_t                    out_side,
  output logic [costh_pkg::M_W-1:0]           out_m
);

  // stage A
  logic                              a_valid_r;
  costh_pkg::meta_t                  a_meta_r, a_meta_nxt;
  logic signed [costh_pkg::L2_W-1:0] dxsq_c, dzsq_c;
  logic [costh_pkg::DSQ_W-1:0]       a_dxsq_r, a_dzsq_r;
  logic [costh_pkg::COORD_W-1:0]     a_magx_r, a_magz_r, magx_nxt, magz_nxt;
  logic                              a_negx_r, a_negz_r;
  // stage B
  logic                              b_valid_r;
  costh_pkg::meta_t                  b_meta_r;
  logic [costh_pkg::L2_W-1:0]        b_l2_r;
  logic [costh_pkg::COORD_W-1:0]     b_magx_r, b_magz_r;
  logic                              b_negx_r, b_negz_r;
  // stage C
  logic                              c_valid_r;
  costh_pkg::side_t                  c_side_r, c_side_nxt;
  logic [costh_pkg::M_W-1:0]         c_m_r, c_m_nxt;
  logic [5:0]                        msb_c;
  logic [4:0]                        h_c;

  // Classify the query and form offsets
  always_comb begin
    a_meta_nxt.kind = costh_pkg::kind_t'(kind);
    if (target_radius <= 0) begin
      a_meta_nxt.reason = costh_pkg::REASON_RADIUS;
    end else if (extent_length <= 0 || extent_width <= 0) begin
      a_meta_nxt.reason = costh_pkg::REASON_EXTENT;
    end else if (dir_x == 0 && dir_z == 0) begin
      a_meta_nxt.reason = costh_pkg::REASON_DIR;
    end else begin
      a_meta_nxt.reason = costh_pkg::REASON_NONE;
    end
    a_meta_nxt.ox  = {target_x[costh_pkg::COORD_W-1], target_x}
                   - {shape_x[costh_pkg::COORD_W-1], shape_x};
    a_meta_nxt.oz  = {target_z[costh_pkg::COORD_W-1], target_z}
                   - {shape_z[costh_pkg::COORD_W-1], shape_z};
    a_meta_nxt.len = extent_length;
    a_meta_nxt.wid = extent_width;
    a_meta_nxt.rad = target_radius;
  end

  assign dxsq_c   = dir_x * dir_x;
  assign dzsq_c   = dir_z * dir_z;
  assign magx_nxt = dir_x[costh_pkg::COORD_W-1] ? costh_pkg::COORD_W'(-dir_x) : dir_x;
  assign magz_nxt = dir_z[costh_pkg::COORD_W-1] ? costh_pkg::COORD_W'(-dir_z) : dir_z;

  // Find the leading one and the even shift that lands it on bit 60 or 61
  always_comb begin
    msb_c = '0;
    for (int i = 0; i < costh_pkg::L2_W; i++) begin
      if (b_l2_r[i]) begin
        msb_c = 6'(i);
      end
    end
    h_c = 5'((7'd61 - {1'b0, msb_c}) >> 1);
    c_m_nxt = costh_pkg::M_W'(b_l2_r) << {h_c, 1'b0};
    c_side_nxt.meta  = b_meta_r;
    c_side_nxt.neg_x = b_negx_r;
    c_side_nxt.neg_z = b_negz_r;
    c_side_nxt.ax    = costh_pkg::ROOT_W'(55'(b_magx_r) << h_c);
    c_side_nxt.az    = costh_pkg::ROOT_W'(55'(b_magz_r) << h_c);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    a_meta_r <= a_meta_nxt;
    a_dxsq_r <= dxsq_c[costh_pkg::DSQ_W-1:0];
    a_dzsq_r <= dzsq_c[costh_pkg::DSQ_W-1:0];
    a_magx_r <= magx_nxt;
    a_magz_r <= magz_nxt;
    a_negx_r <= dir_x[costh_pkg::COORD_W-1];
    a_negz_r <= dir_z[costh_pkg::COORD_W-1];
    b_meta_r <= a_meta_r;
    b_l2_r   <= {1'b0, a_dxsq_r} + {1'b0, a_dzsq_r};
    b_magx_r <= a_magx_r;
    b_magz_r <= a_magz_r;
    b_negx_r <= a_negx_r;
    b_negz_r <= a_negz_r;
    c_side_r <= c_side_nxt;
    c_m_r    <= c_m_nxt;
  end

  assign out_valid = c_valid_r;
  assign out_side  = c_side_r;
  assign out_m     = c_m_r;

endmodule

@@ src/costh_sqrt.sv @@
// ----------------------------------------------------------------------------
// Integer square root pipeline
// One result bit per stage: floor(sqrt(m)) for m below 2^62.
// ----------------------------------------------------------------------------
module costh_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  costh_pkg::side_t             in_side,
  input  logic [costh_pkg::M_W-1:0]    in_m,
  output logic                         out_valid,
  output costh_pkg::side_t             out_side,
  output logic [costh_pkg::ROOT_W-1:0] out_root
);

  localparam int N = costh_pkg::SQRT_STAGES;

  logic                          val_r  [N];
  costh_pkg::side_t              side_r [N];
  logic [costh_pkg::SQRT_W-1:0]  rem_r  [N];
  logic [costh_pkg::SQRT_W-1:0]  root_r [N];
  logic [costh_pkg::SQRT_W-1:0]  rem_in [N];
  logic [costh_pkg::SQRT_W-1:0]  root_in[N];
  logic [costh_pkg::SQRT_W-1:0]  rem_nxt [N];
  logic [costh_pkg::SQRT_W-1:0]  root_nxt[N];

  // Try one bit per stage
  always_comb begin
    logic [costh_pkg::SQRT_W-1:0] bitv;
    logic [costh_pkg::SQRT_W-1:0] trial;
    rem_in[0]  = costh_pkg::SQRT_W'(in_m);
    root_in[0] = '0;
    for (int k = 1; k < N; k++) begin
      rem_in[k]  = rem_r[k-1];
      root_in[k] = root_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      bitv  = costh_pkg::SQRT_W'(1) << (60 - 2 * k);
      trial = root_in[k] + bitv;
      if (rem_in[k] >= trial) begin
        rem_nxt[k]  = rem_in[k] - trial;
        root_nxt[k] = (root_in[k] >> 1) + bitv;
      end else begin
        rem_nxt[k]  = rem_in[k];
        root_nxt[k] = root_in[k] >> 1;
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) begin
        val_r[k] <= 1'b0;
      end
    end else begin
      val_r[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        val_r[k] <= val_r[k-1];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int k = 1; k < N; k++) begin
      side_r[k] <= side_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
    end
  end

  assign out_valid = val_r[N-1];
  assign out_side  = side_r[N-1];
  assign out_root  = root_r[N-1][costh_pkg::ROOT_W-1:0];

endmodule

@@ src/costh_div.sv @@
// ----------------------------------------------------------------------------
// Unit vector divider pipeline
// Two restoring dividers sharing one divisor: q = (a << 30) / root, one
// quotient bit per stage, most significant bit first.
// ----------------------------------------------------------------------------
module costh_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  costh_pkg::side_t             in_side,
  input  logic [costh_pkg::ROOT_W-1:0] in_root,
  output logic                         out_valid,
  output costh_pkg::side_t             out_side,
  output logic [costh_pkg::ROOT_W-1:0] out_qx,
  output logic [costh_pkg::ROOT_W-1:0] out_qz
);

  localparam int N = costh_pkg::DIV_STAGES;

  logic                          val_r  [N];
  costh_pkg::side_t              side_r [N];
  logic [costh_pkg::ROOT_W-1:0]  den_r  [N];
  logic [costh_pkg::REM_W-1:0]   remx_r [N], remz_r [N], remx_nxt[N], remz_nxt[N];
  logic [costh_pkg::ROOT_W-1:0]  qx_r   [N], qz_r   [N], qx_nxt  [N], qz_nxt  [N];
  logic [costh_pkg::ROOT_W-1:0]  den_in [N];
  logic [costh_pkg::REM_W-1:0]   tx_c   [N], tz_c   [N];
  logic [costh_pkg::ROOT_W-1:0]  qx_in  [N], qz_in  [N];
  logic                          gex_c  [N], gez_c  [N];

  // Shift, compare, subtract in each stage
  always_comb begin
    den_in[0] = in_root;
    tx_c[0]   = {1'b0, in_side.ax};
    tz_c[0]   = {1'b0, in_side.az};
    qx_in[0]  = '0;
    qz_in[0]  = '0;
    for (int k = 1; k < N; k++) begin
      den_in[k] = den_r[k-1];
      tx_c[k]   = remx_r[k-1] << 1;
      tz_c[k]   = remz_r[k-1] << 1;
      qx_in[k]  = qx_r[k-1];
      qz_in[k]  = qz_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      gex_c[k]    = tx_c[k] >= {1'b0, den_in[k]};
      gez_c[k]    = tz_c[k] >= {1'b0, den_in[k]};
      remx_nxt[k] = gex_c[k] ? tx_c[k] - {1'b0, den_in[k]} : tx_c[k];
      remz_nxt[k] = gez_c[k] ? tz_c[k] - {1'b0, den_in[k]} : tz_c[k];
      qx_nxt[k]   = {qx_in[k][costh_pkg::ROOT_W-2:0], gex_c[k]};
      qz_nxt[k]   = {qz_in[k][costh_pkg::ROOT_W-2:0], gez_c[k]};
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) begin
        val_r[k] <= 1'b0;
      end
    end else begin
      val_r[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        val_r[k] <= val_r[k-1];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int k = 1; k < N; k++) begin
      side_r[k] <= side_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      den_r[k]  <= den_in[k];
      remx_r[k] <= remx_nxt[k];
      remz_r[k] <= remz_nxt[k];
      qx_r[k]   <= qx_nxt[k];
      qz_r[k]   <= qz_nxt[k];
    end
  end

  assign out_valid = val_r[N-1];
  assign out_side  = side_r[N-1];
  assign out_qx    = qx_r[N-1];
  assign out_qz    = qz_r[N-1];

endmodule

@@ src/costh_geom.sv @@
// ----------------------------------------------------------------------------
// Geometry pipeline
// Projects the offset onto the local axes, rotates for the star, measures
// the squared distance to each rectangle and compares with the contact reach.
// ----------------------------------------------------------------------------
module costh_geom (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  costh_pkg::side_t             in_side,
  input  logic [costh_pkg::ROOT_W-1:0] in_qx,
  input  logic [costh_pkg::ROOT_W-1:0] in_qz,
  input  logic [costh_pkg::TOL_W-1:0]  tol,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [1:0]                   out_reason
);

  localparam int N = costh_pkg::GEOM_STAGES;

  logic             val_r  [N];
  costh_pkg::meta_t meta_r [N];

  // stage 1: unit vector and projection products
  logic signed [costh_pkg::UNIT_W-1:0] fx_c, fz_c;
  logic signed [costh_pkg::OFS_W-1:0]  ox_c, oz_c;
  logic signed [costh_pkg::PROD_W-1:0] p_xf_r, p_zf_r, p_xr_r, p_zr_r;
  // stage 2: local coordinates
  logic signed [costh_pkg::PROD_W:0]   sum_f_c, sum_r_c;
  logic signed [costh_pkg::LOC_W-1:0]  lf2_r, lr2_r;
  // stage 3: star products
  logic signed [costh_pkg::LOC_W-1:0]  lf3_r, lr3_r;
  logic signed [costh_pkg::WIDE_W-1:0] ls3_r, rs3_r;
  logic signed [costh_pkg::UNIT_W-1:0] sin_c;
  // stage 4: rotated coordinates
  logic signed [costh_pkg::WIDE_W-1:0] lfc_c, lrc_c;
  logic signed [costh_pkg::ROT_W-1:0]  lf4_r, lr4_r, a1_r, b1_r, a2_r, b2_r;
  // stage 5: axis gaps and reach
  logic signed [costh_pkg::ROT_W-1:0]  len_c, wid_c, alo0_c;
  logic signed [costh_pkg::ROT_W-1:0]  a1s_c, b1s_c, alo1_c, ahi1_c, blo1_c, bhi1_c;
  logic [costh_pkg::GAP_W-1:0]         gap_r [6], gap_nxt [6];
  logic [costh_pkg::INC_W-1:0]         inc5_r;
  // stage 6: squares
  logic [costh_pkg::DIST_W-1:0]        sq_r [6];
  logic [costh_pkg::DIST_W-1:0]        incsq6_r;
  // stage 7: rectangle distances
  logic [costh_pkg::DIST_W-1:0]        d_r [3];
  logic [costh_pkg::DIST_W-1:0]        incsq7_r;
  // stage 8: least distance
  logic [costh_pkg::DIST_W-1:0]        dmin_r, dmin_nxt, d01_c;
  logic [costh_pkg::DIST_W-1:0]        incsq8_r;
  // stage 9: verdict
  logic                                hit_r, hit_nxt;

  // Sign the quotients and project the offset
  assign fx_c  = in_side.neg_x ? -$signed({1'b0, in_qx}) : $signed({1'b0, in_qx});
  assign fz_c  = in_side.neg_z ? -$signed({1'b0, in_qz}) : $signed({1'b0, in_qz});
  assign ox_c  = $signed(in_side.meta.ox);
  assign oz_c  = $signed(in_side.meta.oz);

  // Sum products and drop to coordinate units with guard bits
  assign sum_f_c = (costh_pkg::PROD_W+1)'(p_xf_r) + (costh_pkg::PROD_W+1)'(p_zf_r);
  assign sum_r_c = (costh_pkg::PROD_W+1)'(p_xr_r) - (costh_pkg::PROD_W+1)'(p_zr_r);

  assign sin_c = $signed({1'b0, costh_pkg::SIN60_Q30});

  // Rotate by plus and minus 60 degrees
  assign lfc_c = costh_pkg::WIDE_W'(lf3_r) <<< costh_pkg::COS60_SHIFT;
  assign lrc_c = costh_pkg::WIDE_W'(lr3_r) <<< costh_pkg::COS60_SHIFT;

  // Select rectangle bounds by kind and take the axis gaps
  always_comb begin
    len_c  = $signed({6'b0, meta_r[3].len, 6'b0});
    wid_c  = $signed({6'b0, meta_r[3].wid, 6'b0});
    alo0_c = (meta_r[3].kind == costh_pkg::KIND_BOX) ? '0 : -len_c;
    if (meta_r[3].kind == costh_pkg::KIND_CROSS) begin
      a1s_c  = lf4_r;
      b1s_c  = lr4_r;
      alo1_c = -wid_c;
      ahi1_c = wid_c;
      blo1_c = -len_c;
      bhi1_c = len_c;
    end else begin
      a1s_c  = a1_r;
      b1s_c  = b1_r;
      alo1_c = -len_c;
      ahi1_c = len_c;
      blo1_c = -wid_c;
      bhi1_c = wid_c;
    end
    gap_nxt[0] = costh_pkg::axis_gap(lf4_r, alo0_c, len_c);
    gap_nxt[1] = costh_pkg::axis_gap(lr4_r, -wid_c, wid_c);
    gap_nxt[2] = costh_pkg::axis_gap(a1s_c, alo1_c, ahi1_c);
    gap_nxt[3] = costh_pkg::axis_gap(b1s_c, blo1_c, bhi1_c);
    gap_nxt[4] = costh_pkg::axis_gap(a2_r, -len_c, len_c);
    gap_nxt[5] = costh_pkg::axis_gap(b2_r, -wid_c, wid_c);
  end

  // Keep the least distance over the rectangles of this kind
  always_comb begin
    d01_c = (d_r[1] < d_r[0]) ? d_r[1] : d_r[0];
    case (meta_r[6].kind)
      costh_pkg::KIND_BOX:   dmin_nxt = d_r[0];
      costh_pkg::KIND_CROSS: dmin_nxt = d01_c;
      default:               dmin_nxt = (d_r[2] < d01_c) ? d_r[2] : d01_c;
    endcase
  end

  assign hit_nxt = (meta_r[7].reason == costh_pkg::REASON_NONE)
                && (meta_r[7].kind != costh_pkg::KIND_UNUSED)
                && (dmin_r <= incsq8_r);

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) begin
        val_r[k] <= 1'b0;
      end
    end else begin
      val_r[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        val_r[k] <= val_r[k-1];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    meta_r[0] <= in_side.meta;
    for (int k = 1; k < N; k++) begin
      meta_r[k] <= meta_r[k-1];
    end
    p_xf_r <= ox_c * fx_c;
    p_zf_r <= oz_c * fz_c;
    p_xr_r <= ox_c * fz_c;
    p_zr_r <= oz_c * fx_c;
    lf2_r  <= sum_f_c[costh_pkg::PROJ_SHIFT +: costh_pkg::LOC_W];
    lr2_r  <= sum_r_c[costh_pkg::PROJ_SHIFT +: costh_pkg::LOC_W];
    lf3_r  <= lf2_r;
    lr3_r  <= lr2_r;
    ls3_r  <= costh_pkg::WIDE_W'(lf2_r) * costh_pkg::WIDE_W'(sin_c);
    rs3_r  <= costh_pkg::WIDE_W'(lr2_r) * costh_pkg::WIDE_W'(sin_c);
    lf4_r  <= costh_pkg::ROT_W'(lf3_r);
    lr4_r  <= costh_pkg::ROT_W'(lr3_r);
    a1_r   <= costh_pkg::ROT_W'((lfc_c + rs3_r) >>> costh_pkg::UNIT_BITS);
    b1_r   <= costh_pkg::ROT_W'((lrc_c - ls3_r) >>> costh_pkg::UNIT_BITS);
    a2_r   <= costh_pkg::ROT_W'((lfc_c - rs3_r) >>> costh_pkg::UNIT_BITS);
    b2_r   <= costh_pkg::ROT_W'((ls3_r + lrc_c) >>> costh_pkg::UNIT_BITS);
    for (int i = 0; i < 6; i++) begin
      gap_r[i] <= gap_nxt[i];
      sq_r[i]  <= costh_pkg::DIST_W'(gap_r[i]) * costh_pkg::DIST_W'(gap_r[i]);
    end
    inc5_r   <= {25'(meta_r[3].rad) + 25'(tol), 6'b0};
    incsq6_r <= costh_pkg::DIST_W'(inc5_r) * costh_pkg::DIST_W'(inc5_r);
    for (int j = 0; j < 3; j++) begin
      d_r[j] <= sq_r[2*j] + sq_r[2*j+1];
    end
    incsq7_r <= incsq6_r;
    dmin_r   <= dmin_nxt;
    incsq8_r <= incsq7_r;
    hit_r    <= hit_nxt;
  end

  assign out_valid  = val_r[N-1];
  assign out_hit    = hit_r;
  assign out_reason = meta_r[N-1].reason;

endmodule

@@ src/circle_oriented_strip_hit_test.sv @@
// ----------------------------------------------------------------------------
// Circle versus oriented strip hit test
// Fully pipelined: one query per cycle, each answered by a result strobe.
// The pipe is made of the 31-stage square root and the 31-stage divider, plus
// three front-end and nine geometry stages. busy stays low.
// Synchronous reset clears all valid bits and sets the tolerance to 3.
// ----------------------------------------------------------------------------
module circle_oriented_strip_hit_test (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_kind,
  input  logic signed [costh_pkg::COORD_W-1:0] in_target_x,
  input  logic signed [costh_pkg::COORD_W-1:0] in_target_z,
  input  logic signed [costh_pkg::COORD_W-1:0] in_target_radius,
  input  logic signed [costh_pkg::COORD_W-1:0] in_shape_x,
  input  logic signed [costh_pkg::COORD_W-1:0] in_shape_z,
  input  logic signed [costh_pkg::COORD_W-1:0] in_dir_x,
  input  logic signed [costh_pkg::COORD_W-1:0] in_dir_z,
  input  logic signed [costh_pkg::COORD_W-1:0] in_extent_length,
  input  logic signed [costh_pkg::COORD_W-1:0] in_extent_width,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [1:0]                          out_reject_reason,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic                              tol_sel;
  logic [costh_pkg::TOL_W-1:0]       tol_val_r;
  logic                              accept;
  logic                              cfg_wr;
  logic                              fe_valid, sq_valid, dv_valid;
  costh_pkg::side_t                  fe_side, sq_side, dv_side;
  logic [costh_pkg::M_W-1:0]         fe_m;
  logic [costh_pkg::ROOT_W-1:0]      sq_root, dv_qx, dv_qz;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign accept  = start && !busy;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign tol_sel = (paddr[2] == costh_pkg::REG_TOL);

  // Hold the contact tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_val_r <= costh_pkg::TOL_RESET;
    end else if (cfg_wr && tol_sel) begin
      tol_val_r <= pwdata[costh_pkg::TOL_W-1:0];
    end
  end

  assign prdata = tol_sel ? 32'(tol_val_r) : '0;

  costh_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (accept),
    .kind          (in_kind),
    .target_x      (in_target_x),
    .target_z      (in_target_z),
    .target_radius (in_target_radius),
    .shape_x       (in_shape_x),
    .shape_z       (in_shape_z),
    .dir_x         (in_dir_x),
    .dir_z         (in_dir_z),
    .extent_length (in_extent_length),
    .extent_width  (in_extent_width),
    .out_valid     (fe_valid),
    .out_side      (fe_side),
    .out_m         (fe_m)
  );

  costh_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fe_valid),
    .in_side   (fe_side),
    .in_m      (fe_m),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .out_root  (sq_root)
  );

  costh_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_side   (sq_side),
    .in_root   (sq_root),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_qx    (dv_qx),
    .out_qz    (dv_qz)
  );

  costh_geom u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (dv_valid),
    .in_side    (dv_side),
    .in_qx      (dv_qx),
    .in_qz      (dv_qz),
    .tol        (tol_val_r),
    .out_valid  (out_valid),
    .out_hit    (out_hit),
    .out_reason (out_reject_reason)
  );

  // Every result beat traces back to an accepted query
  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 74))
    else $error("result beat without a matching query");

  // A rejected query never reports a hit
  a_reject_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reject_reason != costh_pkg::REASON_NONE) |-> !out_hit)
    else $error("hit reported on a rejected query");

  // A tolerance write lands in the register
  a_tol_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && tol_sel) |=> (tol_val_r == $past(pwdata[costh_pkg::TOL_W-1:0])))
    else $error("tolerance write lost");

endmodule

@@ sim/circle_oriented_strip_hit_test_tb.sv @@
// ----------------------------------------------------------------------------
// Circle / oriented strip hit test: self-checking testbench
// Drives directed and random queries through the command port, predicts each
// hit and reject code with a bit-exact software model, and checks every
// result strobe in order. The tolerance register is reprogrammed between
// phases while the pipe is empty.
// ----------------------------------------------------------------------------
module circle_oriented_strip_hit_test_tb;

  typedef struct {
    costh_pkg::kind_t kind;
    logic signed [costh_pkg::COORD_W-1:0] tx, tz, rad, sx, sz, dx, dz, len, wid;
  } query_t;

  typedef struct {
    logic              hit;
    costh_pkg::reason_t reason;
  } verdict_t;

  localparam int CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_kind = '0;
  logic signed [costh_pkg::COORD_W-1:0] in_target_x = '0, in_target_z = '0;
  logic signed [costh_pkg::COORD_W-1:0] in_target_radius = '0;
  logic signed [costh_pkg::COORD_W-1:0] in_shape_x = '0, in_shape_z = '0;
  logic signed [costh_pkg::COORD_W-1:0] in_dir_x = '0, in_dir_z = '0;
  logic signed [costh_pkg::COORD_W-1:0] in_extent_length = '0, in_extent_width = '0;
  logic out_valid, out_hit;
  logic [1:0] out_reject_reason;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  query_t   pending_queries[$];
  verdict_t expected_verdicts[$];
  logic [costh_pkg::TOL_W-1:0] tolerance = costh_pkg::TOL_RESET;
  int  idle_pct = 34;
  bit  beat_taken = 1'b0;
  int  mismatches = 0;
  int  cycles = 0;
  int  queries_sent = 0, hits_seen = 0, rejects_seen = 0;

  circle_oriented_strip_hit_test dut (
    .clk, .rst_n, .start, .busy, .in_kind,
    .in_target_x, .in_target_z, .in_target_radius, .in_shape_x, .in_shape_z,
    .in_dir_x, .in_dir_z, .in_extent_length, .in_extent_width,
    .out_valid, .out_hit, .out_reject_reason,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycles, msg);
    mismatches++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned gap_sq(input longint p, input longint lo,
                                             input longint hi);
    longint g;
    g = 0;
    if (p < lo) g = lo - p;
    else if (p > hi) g = p - hi;
    if (g > (64'sd1 <<< 31)) g = 64'sd1 <<< 31;
    return longint'(g) * longint'(g);
  endfunction

  function automatic longint unsigned box_sq(input longint a, input longint b,
                                             input longint ahi, input longint bhi);
    return gap_sq(a, -ahi, ahi) + gap_sq(b, -bhi, bhi);
  endfunction

  function automatic longint unsigned umin(input longint unsigned a,
                                           input longint unsigned b);
    return a < b ? a : b;
  endfunction

  // Bit-exact hit test: normalize, project, nearest rectangle, compare.
  function automatic verdict_t predict_verdict(input query_t q,
                                               input logic [costh_pkg::TOL_W-1:0] tol);
    verdict_t v;
    longint dx, dz, fx, fz, ox, oz, lf, lr, l_ext, w_ext, a1, b1, a2, b2;
    longint unsigned m, s, mx, mz, near_sq, reach;
    int h;
    v.hit = 1'b0;
    v.reason = costh_pkg::REASON_NONE;
    if (q.rad <= 0) begin v.reason = costh_pkg::REASON_RADIUS; return v; end
    if (q.len <= 0 || q.wid <= 0) begin v.reason = costh_pkg::REASON_EXTENT; return v; end
    if (q.dx == 0 && q.dz == 0) begin v.reason = costh_pkg::REASON_DIR; return v; end
    if (q.kind == costh_pkg::KIND_UNUSED) return v;
    dx = q.dx;
    dz = q.dz;
    m = dx * dx + dz * dz;
    h = 0;
    while (m < (64'd1 << 60)) begin
      m <<= 2;
      h++;
    end
    s = int_sqrt(m);
    mx = dx < 0 ? -dx : dx;
    mz = dz < 0 ? -dz : dz;
    fx = longint'(((mx << h) << costh_pkg::UNIT_BITS) / s);
    fz = longint'(((mz << h) << costh_pkg::UNIT_BITS) / s);
    if (dx < 0) fx = -fx;
    if (dz < 0) fz = -fz;
    ox = longint'(q.tx) - longint'(q.sx);
    oz = longint'(q.tz) - longint'(q.sz);
    lf = (ox * fx + oz * fz) >>> costh_pkg::PROJ_SHIFT;
    lr = (ox * fz - oz * fx) >>> costh_pkg::PROJ_SHIFT;
    l_ext = longint'(q.len) <<< costh_pkg::GUARD_BITS;
    w_ext = longint'(q.wid) <<< costh_pkg::GUARD_BITS;
    case (q.kind)
      costh_pkg::KIND_BOX:
        near_sq = gap_sq(lf, 0, l_ext) + gap_sq(lr, -w_ext, w_ext);
      costh_pkg::KIND_CROSS:
        near_sq = umin(box_sq(lf, lr, l_ext, w_ext), box_sq(lf, lr, w_ext, l_ext));
      default: begin
        // Rotate into the +60 and -60 degree strip frames
        a1 = (lf * (64'sd1 <<< 29) + lr * 64'sd929887697) >>> costh_pkg::UNIT_BITS;
        b1 = (-lf * 64'sd929887697 + lr * (64'sd1 <<< 29)) >>> costh_pkg::UNIT_BITS;
        a2 = (lf * (64'sd1 <<< 29) - lr * 64'sd929887697) >>> costh_pkg::UNIT_BITS;
        b2 = (lf * 64'sd929887697 + lr * (64'sd1 <<< 29)) >>> costh_pkg::UNIT_BITS;
        near_sq = umin(box_sq(lf, lr, l_ext, w_ext),
                       umin(box_sq(a1, b1, l_ext, w_ext), box_sq(a2, b2, l_ext, w_ext)));
      end
    endcase
    reach = (longint'(q.rad) + longint'(tol)) << costh_pkg::GUARD_BITS;
    v.hit = near_sq <= reach * reach;
    return v;
  endfunction

  // Drive: hold a beat until taken, then advance or idle at random
  always @(negedge clk) begin
    if (rst_n && (!start || beat_taken)) begin
      if (pending_queries.size() != 0 && $urandom_range(99) >= idle_pct) begin
        query_t q;
        q = pending_queries.pop_front();
        start <= 1'b1;
        in_kind <= q.kind;
        in_target_x <= q.tx; in_target_z <= q.tz; in_target_radius <= q.rad;
        in_shape_x <= q.sx; in_shape_z <= q.sz; in_dir_x <= q.dx; in_dir_z <= q.dz;
        in_extent_length <= q.len; in_extent_width <= q.wid;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Predict accepted beats, check result strobes in order
  always @(posedge clk) begin
    query_t q;
    verdict_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end else if (rst_n) begin
      beat_taken = start && !busy;
      if (beat_taken) begin
        q.kind = costh_pkg::kind_t'(in_kind);
        q.tx = in_target_x; q.tz = in_target_z; q.rad = in_target_radius;
        q.sx = in_shape_x; q.sz = in_shape_z; q.dx = in_dir_x; q.dz = in_dir_z;
        q.len = in_extent_length; q.wid = in_extent_width;
        expected_verdicts.push_back(predict_verdict(q, tolerance));
        queries_sent++;
      end
      if (out_valid) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result strobe with nothing expected");
        end else begin
          e = expected_verdicts.pop_front();
          if (out_hit !== e.hit)
            report_mismatch($sformatf("hit %b, want %b", out_hit, e.hit));
          if (out_reject_reason !== e.reason)
            report_mismatch($sformatf("reason %0d, want %0d", out_reject_reason, e.reason));
          if (e.hit) hits_seen++;
          if (e.reason != costh_pkg::REASON_NONE) rejects_seen++;
        end
      end
    end
  end

  task automatic write_tolerance(input logic [costh_pkg::TOL_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    tolerance = value;
    @(negedge clk);
    pwrite <= 1'b0; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[costh_pkg::TOL_W-1:0] !== value)
      report_mismatch($sformatf("tolerance reads %0d, want %0d", prdata, value));
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic drain_pipe();
    wait (pending_queries.size() == 0 && !start && expected_verdicts.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic signed [costh_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(3))
      0: return costh_pkg::COORD_W'($urandom);
      1: return costh_pkg::COORD_W'($signed($urandom_range(8191)) - 4096);
      2: return costh_pkg::COORD_W'($signed($urandom_range(1 << 20)) - (1 << 19));
      default: return costh_pkg::COORD_W'($signed($urandom_range(255)) - 128);
    endcase
  endfunction

  function automatic logic signed [costh_pkg::COORD_W-1:0] rand_positive();
    case ($urandom_range(3))
      0: return costh_pkg::COORD_W'($urandom_range(24'h7FFFFF, 1));
      1: return costh_pkg::COORD_W'($urandom_range(255, 1));
      default: return costh_pkg::COORD_W'($urandom_range(8191, 1));
    endcase
  endfunction

  function automatic query_t make_query(input costh_pkg::kind_t k,
                                        input int tx, tz, rad, sx, sz,
                                        input int dx, dz, len, wid);
    query_t q;
    q.kind = k;
    q.tx  = costh_pkg::COORD_W'(tx);  q.tz = costh_pkg::COORD_W'(tz);
    q.rad = costh_pkg::COORD_W'(rad);
    q.sx  = costh_pkg::COORD_W'(sx);  q.sz = costh_pkg::COORD_W'(sz);
    q.dx  = costh_pkg::COORD_W'(dx);  q.dz = costh_pkg::COORD_W'(dz);
    q.len = costh_pkg::COORD_W'(len); q.wid = costh_pkg::COORD_W'(wid);
    return q;
  endfunction

  // Mostly valid queries with the target near the shape, some noise
  function automatic query_t rand_query();
    query_t q;
    q.kind = costh_pkg::kind_t'($urandom_range(99) < 4 ? 3 : $urandom_range(2));
    q.sx = rand_coord(); q.sz = rand_coord();
    q.dx = rand_coord(); q.dz = rand_coord();
    q.len = rand_positive(); q.wid = rand_positive(); q.rad = rand_positive();
    if ($urandom_range(99) < 80) begin
      q.tx = q.sx + costh_pkg::COORD_W'($signed($urandom_range(4096)) - 2048);
      q.tz = q.sz + costh_pkg::COORD_W'($signed($urandom_range(4096)) - 2048);
    end else begin
      q.tx = rand_coord(); q.tz = rand_coord();
    end
    case ($urandom_range(19))
      0: q.rad = -costh_pkg::COORD_W'($urandom_range(24'h800000));
      1: q.len = -costh_pkg::COORD_W'($urandom_range(24'h800000));
      2: q.wid = '0;
      3: begin q.dx = '0; q.dz = '0; end
      default: ;
    endcase
    return q;
  endfunction

  localparam int MAXP = 8388607;
  localparam int MINN = -8388608;

  initial begin
    logic [costh_pkg::TOL_W-1:0] settings[4];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: rejects in priority order, each kind, extremes
    pending_queries.push_back(make_query(costh_pkg::KIND_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_queries.push_back(make_query(costh_pkg::KIND_BOX, 0, 0, MINN, 0, 0,
                                         1, 0, 10, 10));
    pending_queries.push_back(make_query(costh_pkg::KIND_BOX, 0, 0, 5, 0, 0, 1, 0, 0, 10));
    pending_queries.push_back(make_query(costh_pkg::KIND_CROSS, 0, 0, 5, 0, 0,
                                         1, 0, 10, MINN));
    pending_queries.push_back(make_query(costh_pkg::KIND_STAR, 0, 0, 5, 0, 0,
                                         0, 0, 10, 10));
    pending_queries.push_back(make_query(costh_pkg::KIND_UNUSED, 0, 0, 5, 0, 0,
                                         1, 0, 10, 10));
    pending_queries.push_back(make_query(costh_pkg::KIND_BOX, 512, 0, 256, 0, 0,
                                         256, 0, 1024, 256));
    pending_queries.push_back(make_query(costh_pkg::KIND_BOX, -2000, 0, 256, 0, 0,
                                         256, 0, 1024, 256));
    pending_queries.push_back(make_query(costh_pkg::KIND_BOX, -259, 0, 256, 0, 0,
                                         1, 0, 1024, 256));
    pending_queries.push_back(make_query(costh_pkg::KIND_CROSS, 0, 900, 16, 0, 0,
                                         0, -1, 1024, 64));
    pending_queries.push_back(make_query(costh_pkg::KIND_CROSS, 600, 600, 16, 0, 0,
                                         3, 4, 1024, 64));
    pending_queries.push_back(make_query(costh_pkg::KIND_STAR, 500, 866, 16, 0, 0,
                                         256, 0, 1024, 64));
    pending_queries.push_back(make_query(costh_pkg::KIND_STAR, 500, -866, 8, 0, 0,
                                         1, 0, 1024, 32));
    pending_queries.push_back(make_query(costh_pkg::KIND_STAR, 0, 900, 8, 0, 0,
                                         1, 0, 1024, 32));
    pending_queries.push_back(make_query(costh_pkg::KIND_BOX, MAXP, MAXP, MAXP, MINN, MINN,
                                         MINN, MINN, MAXP, MAXP));
    pending_queries.push_back(make_query(costh_pkg::KIND_STAR, MINN, MAXP, 1, MAXP, MINN,
                                         MAXP, MINN, 1, 1));
    pending_queries.push_back(make_query(costh_pkg::KIND_CROSS, MINN, MINN, MAXP, MAXP, MAXP,
                                         MINN, 0, MAXP, 1));
    pending_queries.push_back(make_query(costh_pkg::KIND_BOX, 3, -7, 1, 0, 0,
                                         0, MAXP, 1, 1));
    pending_queries.push_back(make_query(costh_pkg::KIND_STAR, -1, -1, 1, 0, 0,
                                         -1, 1, 1, 1));
    drain_pipe();

    // Random phases, one per tolerance setting; one with no idling
    settings = '{12'd0, 12'd4095, 12'(($urandom_range(4094, 1))), costh_pkg::TOL_RESET};
    foreach (settings[p]) begin
      write_tolerance(settings[p]);
      idle_pct = (p == 1) ? 0 : 34;
      repeat (220) pending_queries.push_back(rand_query());
      drain_pipe();
    end

    $display("Ran %0d queries over five tolerance phases: %0d hits, %0d rejects",
             queries_sent, hits_seen, rejects_seen);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches,
               expected_verdicts.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ circle_oriented_strip_hit_test.f @@
src/costh_pkg.sv
src/costh_front.sv
src/costh_sqrt.sv
src/costh_div.sv
src/costh_geom.sv
src/circle_oriented_strip_hit_test.sv
sim/circle_oriented_strip_hit_test_tb.sv
